// ===== rtl/tgesm_pkg.sv =====
// shared types and constants for the tile grid edge segment merger
// no dependencies; imported by tgesm_seg_if and every rtl module
package tgesm_pkg;

  // fixed field widths
  localparam int SEG_W   = 14;
  localparam int ID_W    = 15;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SIDE_W  = 2;
  localparam int NUM_SIDES = 4;

  // parameter defaults for the top level
  localparam int MAX_COLUMNS_DEF   = 64;
  localparam int MAX_ROWS_DEF      = 64;
  localparam int TILE_PIXELS_W_DEF = 32;
  localparam int TILE_PIXELS_H_DEF = 32;

  // register reset values
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // edge side codes, also the bit positions in the side masks
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd3;

  // queue between classifier and emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified obstacle cell
  typedef struct packed {
    logic [NUM_SIDES-1:0]            side_mask;
    logic [NUM_SIDES-1:0]            new_mask;
    logic [NUM_SIDES-1:0][SEG_W-1:0] seg;
    logic [COORD_W-1:0]              tx;
    logic [COORD_W-1:0]              ty;
  } cell_rec_t;

  typedef struct packed {
    logic      valid;
    cell_rec_t rec;
  } queue_wr_t;

  typedef struct packed {
    logic      valid;
    cell_rec_t rec;
  } queue_rd_t;

endpackage

// ===== rtl/tgesm_cell_if.sv =====
// input channel: one grid cell with its neighbor obstacle flags
// depends on tgesm_pkg only by convention; payload is single bits
interface tgesm_cell_if;
  logic valid;
  logic ready;
  logic cell_obstacle;
  logic left_obstacle;
  logic right_obstacle;
  logic up_obstacle;
  logic down_obstacle;

  modport source (
    output valid, cell_obstacle, left_obstacle, right_obstacle, up_obstacle, down_obstacle,
    input  ready
  );
  modport sink (
    input  valid, cell_obstacle, left_obstacle, right_obstacle, up_obstacle, down_obstacle,
    output ready
  );
endinterface

// ===== rtl/tgesm_seg_if.sv =====
// result channel: one segment creation or extension
// field widths come from tgesm_pkg
interface tgesm_seg_if;
  import tgesm_pkg::*;
  logic               valid;
  logic               ready;
  logic [SEG_W-1:0]   seg_index;
  logic               is_new;
  logic [SIDE_W-1:0]  edge_side;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic               last_of_cell;

  modport source (
    output valid, seg_index, is_new, edge_side, x_start, y_start, x_end, y_end, last_of_cell,
    input  ready
  );
  modport sink (
    input  valid, seg_index, is_new, edge_side, x_start, y_start, x_end, y_end, last_of_cell,
    output ready
  );
endinterface

// ===== rtl/tile_grid_edge_segment_merger.sv =====
// top level of the tile grid edge segment merger: classifier, queue, emitter
// uses tgesm_pkg, tgesm_cell_if, tgesm_seg_if, tgesm_front, tgesm_queue, tgesm_back
//
//   channel   dir   handshake            payload
//   in_cell   in    valid/ready          cell and four neighbor obstacle flags
//   out_seg   out   valid/ready          seg_index, is_new, edge_side, start, end, last
//   cfg       in    cfg_we (no stall)    cfg_idx selects grid_width or grid_height
//
// a cell is classified in the cycle it is accepted; one cell can enter every cycle
// while the two-entry queue has room
// results leave one per cycle while out_seg is ready, so a cell with k exposed sides
// gives k results on the result port, one per exposed side
// reset is synchronous; the column store is not cleared and needs no reset pass
// a stalled result waits in the output register; cells keep entering until the
// queue holds two records
module tile_grid_edge_segment_merger #(
  parameter int MAX_COLUMNS   = tgesm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = tgesm_pkg::MAX_ROWS_DEF,
  parameter int TILE_PIXELS_W = tgesm_pkg::TILE_PIXELS_W_DEF,
  parameter int TILE_PIXELS_H = tgesm_pkg::TILE_PIXELS_H_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tgesm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tgesm_pkg::CFG_W-1:0]     cfg_wdata,
  tgesm_cell_if.sink                      in_cell,
  tgesm_seg_if.source                     out_seg
);
  import tgesm_pkg::*;

  queue_wr_t q_wr;
  queue_rd_t q_rd;
  logic      q_full;
  logic      q_pop;

  tgesm_front #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .TILE_PIXELS_W (TILE_PIXELS_W),
    .TILE_PIXELS_H (TILE_PIXELS_H)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_cell   (in_cell),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  tgesm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  tgesm_back #(
    .TILE_PIXELS_W (TILE_PIXELS_W),
    .TILE_PIXELS_H (TILE_PIXELS_H)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rd    (q_rd),
    .q_pop   (q_pop),
    .out_seg (out_seg)
  );

  // a classified record is never dropped at the queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("record pushed into a full queue");

  // records only leave when present
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("queue popped while empty");

  // retiring a record always shows its last result next
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && q_pop) |=> (out_seg.valid && out_seg.last_of_cell))
    else $error("record retired without a last result");

  // every queued record has at least one side to emit
  a_head_sides: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd.valid |-> (q_rd.rec.side_mask != '0))
    else $error("queued record has no exposed side");

endmodule

// ===== rtl/tgesm_front.sv =====
// classifier: config registers, scan position, segment counter and column store
// uses tgesm_pkg and tgesm_cell_if; pushes one record per obstacle cell with exposed sides
module tgesm_front #(
  parameter int MAX_COLUMNS   = tgesm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = tgesm_pkg::MAX_ROWS_DEF,
  parameter int TILE_PIXELS_W = tgesm_pkg::TILE_PIXELS_W_DEF,
  parameter int TILE_PIXELS_H = tgesm_pkg::TILE_PIXELS_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tgesm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tgesm_pkg::CFG_W-1:0]    cfg_wdata,
  tgesm_cell_if.sink                     in_cell,
  input  logic                           q_full,
  output tgesm_pkg::queue_wr_t           q_wr
);
  import tgesm_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CXW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RXW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [ID_W-1:0]  seg_cnt_r, seg_cnt_nxt;
  logic [ID_W-1:0]  above_left_id_r, above_right_id_r;

  // column store: top id in the upper half, bottom id in the lower half
  logic [2*ID_W-1:0] col_mem [MAX_ROWS];
  logic [2*ID_W-1:0] rd_word_r;
  logic [2*ID_W-1:0] wr_word;

  logic acc;
  logic [CXW-1:0] w_cfg_x, w_eff, col_inc;
  logic [RXW-1:0] h_cfg_x, h_eff, row_inc;
  logic row_wrap, grid_end;

  logic [NUM_SIDES-1:0]            exposed, is_new;
  logic [NUM_SIDES-1:0][ID_W-1:0]  nb_id, new_id;
  logic [NUM_SIDES-1:0][SEG_W-1:0] seg;
  logic [ID_W-1:0]                 run;
  logic [31:0] tx_full, ty_full;

  assign in_cell.ready = !q_full;
  assign acc = in_cell.valid && in_cell.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective grid size: zero means one, clamp at MAX_COLUMNS and MAX_ROWS
  assign w_cfg_x = CXW'(grid_width_r);
  assign h_cfg_x = RXW'(grid_height_r);
  assign w_eff = (w_cfg_x == '0) ? CXW'(1) :
                 (w_cfg_x > CXW'(MAX_COLUMNS)) ? CXW'(MAX_COLUMNS) : w_cfg_x;
  assign h_eff = (h_cfg_x == '0) ? RXW'(1) :
                 (h_cfg_x > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : h_cfg_x;

  assign col_inc  = CXW'(col_r) + CXW'(1);
  assign row_inc  = RXW'(row_r) + RXW'(1);
  assign row_wrap = (row_inc >= h_eff);
  assign grid_end = row_wrap && (col_inc >= w_eff);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (acc) begin
      if (row_wrap) begin
        row_nxt = '0;
        col_nxt = (col_inc >= w_eff) ? '0 : col_inc[CW-1:0];
      end else begin
        row_nxt = row_inc[RW-1:0];
      end
    end
  end

  // neighbor ids; first row and first column see nothing
  assign nb_id[SIDE_LEFT]   = (row_r == '0) ? '0 : above_left_id_r;
  assign nb_id[SIDE_RIGHT]  = (row_r == '0) ? '0 : above_right_id_r;
  assign nb_id[SIDE_TOP]    = (col_r == '0) ? '0 : rd_word_r[2*ID_W-1:ID_W];
  assign nb_id[SIDE_BOTTOM] = (col_r == '0) ? '0 : rd_word_r[ID_W-1:0];

  assign exposed[SIDE_LEFT]   = in_cell.cell_obstacle && !in_cell.left_obstacle;
  assign exposed[SIDE_RIGHT]  = in_cell.cell_obstacle && !in_cell.right_obstacle;
  assign exposed[SIDE_TOP]    = in_cell.cell_obstacle && !in_cell.up_obstacle;
  assign exposed[SIDE_BOTTOM] = in_cell.cell_obstacle && !in_cell.down_obstacle;

  // new segments take consecutive numbers in side order
  always_comb begin
    run = seg_cnt_r;
    for (int i = 0; i < NUM_SIDES; i++) begin
      is_new[i] = exposed[i] && (nb_id[i] == '0);
      if (is_new[i]) begin
        seg[i] = run[SEG_W-1:0];
        run    = run + ID_W'(1);
      end else begin
        seg[i] = SEG_W'(nb_id[i] - ID_W'(1));
      end
      new_id[i] = exposed[i] ? (ID_W'(seg[i]) + ID_W'(1)) : '0;
    end
  end

  assign seg_cnt_nxt = grid_end ? '0 : run;

  assign tx_full = 32'(col_r) * 32'(TILE_PIXELS_W);
  assign ty_full = 32'(row_r) * 32'(TILE_PIXELS_H);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r            <= '0;
      row_r            <= '0;
      seg_cnt_r        <= '0;
      above_left_id_r  <= '0;
      above_right_id_r <= '0;
    end else if (acc) begin
      col_r            <= col_nxt;
      row_r            <= row_nxt;
      seg_cnt_r        <= seg_cnt_nxt;
      above_left_id_r  <= new_id[SIDE_LEFT];
      above_right_id_r <= new_id[SIDE_RIGHT];
    end
  end

  assign wr_word = {new_id[SIDE_TOP], new_id[SIDE_BOTTOM]};

  // read ahead for the next cell's row, forwarding a same-slot write
  always_ff @(posedge clk) begin
    if (acc) begin
      col_mem[row_r] <= wr_word;
    end
    if (acc && (row_nxt == row_r)) begin
      rd_word_r <= wr_word;
    end else begin
      rd_word_r <= col_mem[row_nxt];
    end
  end

  always_comb begin
    q_wr.valid         = acc && (exposed != '0);
    q_wr.rec.side_mask = exposed;
    q_wr.rec.new_mask  = is_new;
    q_wr.rec.seg       = seg;
    q_wr.rec.tx        = tx_full[COORD_W-1:0];
    q_wr.rec.ty        = ty_full[COORD_W-1:0];
  end

endmodule

// ===== rtl/tgesm_queue.sv =====
// short queue of classified cell records between classifier and emitter
// uses tgesm_pkg for the record type and depth
module tgesm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tgesm_pkg::queue_wr_t q_wr,
  output logic                 q_full,
  input  logic                 q_pop,
  output tgesm_pkg::queue_rd_t q_rd
);
  import tgesm_pkg::*;

  cell_rec_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign q_full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push   = q_wr.valid && !q_full;
  assign pop    = q_pop && (count_r != '0);

  assign q_rd.valid = (count_r != '0);
  assign q_rd.rec   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= q_wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tgesm_back.sv =====
// emitter: walks the exposed sides of the head record, one result per cycle while out_seg is not stalled
// uses tgesm_pkg and tgesm_seg_if; output register decouples the result channel
module tgesm_back #(
  parameter int TILE_PIXELS_W = tgesm_pkg::TILE_PIXELS_W_DEF,
  parameter int TILE_PIXELS_H = tgesm_pkg::TILE_PIXELS_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tgesm_pkg::queue_rd_t q_rd,
  output logic                 q_pop,
  tgesm_seg_if.source          out_seg
);
  import tgesm_pkg::*;

  logic [NUM_SIDES-1:0] done_r, pend, rest, sel;
  logic [SIDE_W-1:0]    side;
  logic                 last, load, cur_new;
  logic [COORD_W-1:0]   tw, th, x_right, y_low;
  logic [COORD_W-1:0]   xs, ys, xe, ye;

  logic               out_valid_r;
  logic [SEG_W-1:0]   seg_index_r;
  logic               is_new_r;
  logic [SIDE_W-1:0]  edge_side_r;
  logic [COORD_W-1:0] x_start_r, y_start_r, x_end_r, y_end_r;
  logic               last_of_cell_r;

  assign pend = q_rd.rec.side_mask & ~done_r;

  always_comb begin
    if (pend[SIDE_LEFT]) begin
      side = SIDE_LEFT;
    end else if (pend[SIDE_RIGHT]) begin
      side = SIDE_RIGHT;
    end else if (pend[SIDE_TOP]) begin
      side = SIDE_TOP;
    end else begin
      side = SIDE_BOTTOM;
    end
  end

  assign sel  = NUM_SIDES'(1) << side;
  assign rest = pend & ~sel;
  assign last = (rest == '0);
  assign load = q_rd.valid && (!out_valid_r || out_seg.ready);
  assign q_pop = load && last;
  assign cur_new = q_rd.rec.new_mask[side];

  assign tw      = COORD_W'(TILE_PIXELS_W);
  assign th      = COORD_W'(TILE_PIXELS_H);
  assign x_right = q_rd.rec.tx + tw;
  assign y_low   = q_rd.rec.ty + th;

  always_comb begin
    xs = q_rd.rec.tx;
    ys = q_rd.rec.ty;
    xe = x_right;
    ye = y_low;
    unique case (side)
      SIDE_LEFT: begin
        xe = q_rd.rec.tx;
      end
      SIDE_RIGHT: begin
        xs = x_right;
      end
      SIDE_TOP: begin
        ye = q_rd.rec.ty;
      end
      SIDE_BOTTOM: begin
        ys = y_low;
      end
      default: ;
    endcase
    // start point only means something on a new segment
    if (!cur_new) begin
      xs = '0;
      ys = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r      <= last ? '0 : (done_r | sel);
        out_valid_r <= 1'b1;
      end else if (out_seg.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_index_r    <= q_rd.rec.seg[side];
      is_new_r       <= cur_new;
      edge_side_r    <= side;
      x_start_r      <= xs;
      y_start_r      <= ys;
      x_end_r        <= xe;
      y_end_r        <= ye;
      last_of_cell_r <= last;
    end
  end

  assign out_seg.valid        = out_valid_r;
  assign out_seg.seg_index    = seg_index_r;
  assign out_seg.is_new       = is_new_r;
  assign out_seg.edge_side    = edge_side_r;
  assign out_seg.x_start      = x_start_r;
  assign out_seg.y_start      = y_start_r;
  assign out_seg.x_end        = x_end_r;
  assign out_seg.y_end        = y_end_r;
  assign out_seg.last_of_cell = last_of_cell_r;

endmodule
